[rtl/core/bpa_pkg.sv]
// Shared types and constants of the bitmap page allocator.
`timescale 1ns / 1ps
package bpa_pkg;

  // Page numbers and range ends inside the sequencer; one bit above 65535 pages.
  localparam int PW = 17;

  // Largest page an allocation may reach, exclusive.
  localparam int ALLOC_CAP = 32768;

  // Request kinds.
  typedef enum logic [1:0] {
    KIND_ALLOC     = 2'd0,
    KIND_FREE      = 2'd1,
    KIND_MARK_FREE = 2'd2,
    KIND_MARK_BUSY = 2'd3
  } bpa_kind_t;

  // Operations of the byte unit.
  typedef enum logic [1:0] {
    OP_FIND = 2'd0,
    OP_SET  = 2'd1,
    OP_CLR  = 2'd2
  } bpa_op_t;

  // Control word for the byte unit: operation and page offsets inside the byte.
  typedef struct packed {
    bpa_op_t    op;
    logic [2:0] first;
    logic [2:0] last;
  } bpa_unit_ctrl_t;

  // Sequencer states.
  typedef enum logic [5:0] {
    S_CLEAR = 6'b000001,
    S_IDLE  = 6'b000010,
    S_CHECK = 6'b000100,
    S_EVAL  = 6'b001000,
    S_DONE  = 6'b010000,
    S_SPARE = 6'b100000
  } bpa_state_t;

  // Register word index of max_page.
  localparam logic REG_MAX_PAGE = 1'b0;

endpackage

[rtl/core/bitmap_page_allocator.sv]
// Top level of the next-fit bitmap page allocator.
`timescale 1ns / 1ps
// The allocator keeps one bit per physical page in an on-chip byte memory, a set bit
// meaning occupied, and serves one request at a time: allocate (next-fit search from
// the last page handed out, wrapping to page 1), checked free of one page, and marking
// a range free or occupied. After reset a clearing pass writes every bitmap byte to
// all-occupied, one byte a cycle, over min(BITMAP_BYTES, 8192) bytes; no word is
// accepted meanwhile, while max_page can be written at any time. Each request then
// visits its bitmap bytes one per read/evaluate pair, since the single memory read port
// and the shared byte unit handle one byte each, with setup and result hand-off around
// the search; a refused free skips the search. A finished result sits in the output
// register, and the next word is taken once the sequencer is idle.
module bitmap_page_allocator
  import bpa_pkg::*;
#(
  parameter int BITMAP_BYTES = 4096
) (
  input  logic        clk,
  input  logic        rst_n,
  // Request stream.
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // [14:0] page_number, [30:15] range_len, [31] zero
  input  logic [1:0]  in_tuser,   // [1:0] kind
  // Result stream.
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // [14:0] allocated_page, [15] zero
  output logic [0:0]  out_tuser,  // [0] status
  // Configuration port.
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  // Pages above 65535 are never reached by any request.
  localparam int MEM_BYTES = (BITMAP_BYTES < 8192) ? BITMAP_BYTES : 8192;
  localparam int PAGE_CAP  = MEM_BYTES * 8;
  localparam int LIM_CAP   = (PAGE_CAP < ALLOC_CAP) ? PAGE_CAP : ALLOC_CAP;
  localparam int MAW       = (MEM_BYTES > 1) ? $clog2(MEM_BYTES) : 1;

  localparam logic [PW-1:0]  PAGE_CAP_W = PW'(PAGE_CAP);
  localparam logic [PW-1:0]  LIM_CAP_W  = PW'(LIM_CAP);
  localparam logic [MAW-1:0] CLR_LAST   = MAW'(MEM_BYTES - 1);

  // Bitmap memory.
  logic [7:0]     mem [MEM_BYTES];
  logic [7:0]     rd_data_r;
  logic           mem_we;
  logic [MAW-1:0] mem_waddr;
  logic [7:0]     mem_wdata;
  logic [MAW-1:0] mem_raddr;

  // Sequencer state.
  bpa_state_t     state_r,   state_nxt;
  logic [MAW-1:0] clr_r,     clr_nxt;
  logic [PW-1:0]  cur_r,     cur_nxt;
  logic [PW-1:0]  end_r,     end_nxt;
  logic           alloc_r,   alloc_nxt;
  logic           pass2_r,   pass2_nxt;
  bpa_op_t        op_r,      op_nxt;
  logic [14:0]    sp_r,      sp_nxt;
  logic [15:0]    max_page_r;
  logic [14:0]    res_page_r,   res_page_nxt;
  logic           res_status_r, res_status_nxt;
  logic           out_valid_r,  out_valid_nxt;
  logic [14:0]    out_page_r,   out_page_nxt;
  logic           out_status_r, out_status_nxt;

  // Request fields.
  logic [1:0]     req_kind;
  logic [14:0]    req_page;
  logic [15:0]    req_count;
  logic [PW-1:0]  req_end;
  logic [PW-1:0]  lim;
  logic [PW-1:0]  wrap_end;
  logic [PW-1:0]  last_page;
  logic [PW-1:0]  next_cur;

  // Byte unit connections.
  bpa_unit_ctrl_t unit_ctrl;
  logic           unit_found;
  logic [2:0]     unit_off;
  logic [7:0]     unit_data;

  assign req_kind  = in_tuser;
  assign req_page  = in_tdata[14:0];
  assign req_count = in_tdata[30:15];

  // Range end of a mark, clipped to the pages the memory holds.
  always_comb begin
    req_end = PW'(req_page) + PW'(req_count);
    if (req_end > PAGE_CAP_W) begin
      req_end = PAGE_CAP_W;
    end
  end

  // Allocation limit and the end of the wrapped pass.
  assign lim      = ({1'b0, max_page_r} < LIM_CAP_W) ? {1'b0, max_page_r} : LIM_CAP_W;
  assign wrap_end = (PW'(sp_r) < lim) ? PW'(sp_r) : lim;

  // Offsets of the current byte that lie in the range.
  assign last_page = end_r - PW'(1);
  assign next_cur  = {cur_r[PW-1:3] + (PW-3)'(1), 3'b000};
  assign unit_ctrl.op    = op_r;
  assign unit_ctrl.first = cur_r[2:0];
  assign unit_ctrl.last  = (last_page[PW-1:3] == cur_r[PW-1:3]) ? last_page[2:0] : 3'd7;

  bpa_byte_unit u_byte_unit (
    .ctrl      (unit_ctrl),
    .data_in   (rd_data_r),
    .found     (unit_found),
    .found_off (unit_off),
    .data_out  (unit_data)
  );

  // Sequencer.
  always_comb begin
    state_nxt      = state_r;
    clr_nxt        = clr_r;
    cur_nxt        = cur_r;
    end_nxt        = end_r;
    alloc_nxt      = alloc_r;
    pass2_nxt      = pass2_r;
    op_nxt         = op_r;
    sp_nxt         = sp_r;
    res_page_nxt   = res_page_r;
    res_status_nxt = res_status_r;
    mem_we         = 1'b0;
    mem_waddr      = cur_r[MAW+2:3];
    mem_wdata      = unit_data;
    mem_raddr      = cur_r[MAW+2:3];

    case (state_r)
      S_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_r;
        mem_wdata = 8'hFF;
        if (clr_r == CLR_LAST) begin
          state_nxt = S_IDLE;
        end else begin
          clr_nxt = clr_r + MAW'(1);
        end
      end
      S_IDLE: begin
        if (in_tvalid) begin
          res_page_nxt   = 15'd0;
          res_status_nxt = 1'b0;
          alloc_nxt      = 1'b0;
          pass2_nxt      = 1'b0;
          cur_nxt        = PW'(req_page);
          state_nxt      = S_CHECK;
          case (req_kind)
            KIND_ALLOC: begin
              alloc_nxt = 1'b1;
              op_nxt    = OP_FIND;
              cur_nxt   = PW'(sp_r);
              end_nxt   = lim;
            end
            KIND_FREE: begin
              op_nxt  = OP_CLR;
              end_nxt = PW'(req_page) + PW'(1);
              if (req_page == 15'd0 || {1'b0, req_page} >= max_page_r ||
                  PW'(req_page) >= PAGE_CAP_W) begin
                res_status_nxt = 1'b1;
                state_nxt      = S_DONE;
              end
            end
            KIND_MARK_FREE: begin
              op_nxt  = OP_CLR;
              end_nxt = req_end;
            end
            KIND_MARK_BUSY: begin
              op_nxt  = OP_SET;
              end_nxt = req_end;
            end
            default: begin
              state_nxt = S_DONE;
            end
          endcase
        end
      end
      S_CHECK: begin
        if (cur_r < end_r) begin
          state_nxt = S_EVAL;
        end else if (alloc_r && !pass2_r) begin
          pass2_nxt = 1'b1;
          cur_nxt   = PW'(1);
          end_nxt   = wrap_end;
        end else begin
          res_status_nxt = alloc_r;
          state_nxt      = S_DONE;
        end
      end
      S_EVAL: begin
        if (op_r == OP_FIND) begin
          if (unit_found) begin
            mem_we       = 1'b1;
            res_page_nxt = {cur_r[14:3], unit_off};
            sp_nxt       = {cur_r[14:3], unit_off};
            state_nxt    = S_DONE;
          end else begin
            cur_nxt   = next_cur;
            state_nxt = S_CHECK;
          end
        end else begin
          mem_we    = 1'b1;
          cur_nxt   = next_cur;
          state_nxt = S_CHECK;
        end
      end
      S_DONE: begin
        if (!out_valid_r || out_tready) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Output register: loaded from the result when the sequencer hands it off.
  always_comb begin
    out_valid_nxt  = out_valid_r;
    out_page_nxt   = out_page_r;
    out_status_nxt = out_status_r;
    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end
    if (state_r == S_DONE && (!out_valid_r || out_tready)) begin
      out_valid_nxt  = 1'b1;
      out_page_nxt   = res_page_r;
      out_status_nxt = res_status_r;
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_r       <= '0;
      sp_r        <= 15'd1;
      out_valid_r <= 1'b0;
      alloc_r     <= 1'b0;
      pass2_r     <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      sp_r        <= sp_nxt;
      out_valid_r <= out_valid_nxt;
      alloc_r     <= alloc_nxt;
      pass2_r     <= pass2_nxt;
    end
  end

  // Working and result registers.
  always_ff @(posedge clk) begin
    cur_r        <= cur_nxt;
    end_r        <= end_nxt;
    op_r         <= op_nxt;
    res_page_r   <= res_page_nxt;
    res_status_r <= res_status_nxt;
    out_page_r   <= out_page_nxt;
    out_status_r <= out_status_nxt;
  end

  // Bitmap memory: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rd_data_r <= mem[mem_raddr];
  end

  // Configuration register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_page_r <= 16'd0;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready &&
                 cfg_paddr[2] == REG_MAX_PAGE) begin
      max_page_r <= cfg_pwdata[15:0];
    end
  end

  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr[2] == REG_MAX_PAGE) ? {16'd0, max_page_r} : 32'd0;

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {1'b0, out_page_r};
  assign out_tuser  = out_status_r;

endmodule

[rtl/core/bpa_byte_unit.sv]
// Byte unit of the page allocator: first-free search, range set and range clear.
`timescale 1ns / 1ps
module bpa_byte_unit
  import bpa_pkg::*;
(
  input  bpa_unit_ctrl_t ctrl,
  input  logic [7:0]     data_in,
  output logic           found,
  output logic [2:0]     found_off,
  output logic [7:0]     data_out
);

  logic [7:0] mask;
  logic [7:0] hit;

  // Page offset j sits in bit 7-j; build the mask over offsets first..last.
  always_comb begin
    for (int j = 0; j < 8; j++) begin
      mask[7-j] = (3'(j) >= ctrl.first) && (3'(j) <= ctrl.last);
    end
  end

  assign hit = mask & ~data_in;

  // Lowest page offset that is free inside the mask.
  always_comb begin
    found     = 1'b0;
    found_off = 3'd0;
    for (int j = 7; j >= 0; j--) begin
      if (hit[7-j]) begin
        found     = 1'b1;
        found_off = 3'(j);
      end
    end
  end

  // New byte contents for each operation.
  always_comb begin
    case (ctrl.op)
      OP_FIND: data_out = data_in | (8'h80 >> found_off);
      OP_SET:  data_out = data_in | mask;
      OP_CLR:  data_out = data_in & ~mask;
      default: data_out = data_in;
    endcase
  end

endmodule

[rtl/core/bpa_checker.sv]
// Port-level checker of the bitmap page allocator and its bind.
`timescale 1ns / 1ps
module bpa_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [15:0] out_tdata,
  input logic [0:0]  out_tuser,
  input logic        cfg_pready
);

  // A waiting result word holds still.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result word changed while stalled");

  // A failed request never reports a page.
  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[0] |-> out_tdata[14:0] == 15'd0)
    else $error("failure status with nonzero page");

  // The sequencer leaves idle as soon as a request word is taken.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("request taken while busy");

  // No result appears right out of reset.
  a_no_result_after_reset: assert property (@(posedge clk) disable iff (!rst_n)
    $past(!rst_n) |-> !out_tvalid)
    else $error("result valid right after reset");

  // The configuration port never inserts wait states.
  a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_pready)
    else $error("configuration port not ready");

endmodule

bind bitmap_page_allocator bpa_checker u_bpa_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .cfg_pready (cfg_pready)
);
